// ===== hw/rtl/pcrm_pkg.sv =====
// pcrm_pkg: shared types and codes for the packet capture ring manager
// no dependencies; used by every pcrm module and the core top level

package pcrm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DESCRIPTOR_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DESTINATION       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUNOUT_POLICY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES      = 3'd5;

  localparam logic [1:0] DEST_CONSOLE = 2'd0;
  localparam logic [1:0] DEST_MEMORY  = 2'd1;
  localparam logic [1:0] DEST_BOTH    = 2'd2;
  localparam logic [1:0] DEST_BAD     = 2'd3;

  localparam logic [1:0] POLICY_WRAP    = 2'd0;
  localparam logic [1:0] POLICY_NOTIFY  = 2'd1;
  localparam logic [1:0] POLICY_DISCARD = 2'd2;
  localparam logic [1:0] POLICY_BAD     = 2'd3;

  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_REWIND = 1'b1;

  typedef struct packed {
    logic        capture_enable;
    logic        descriptor_enable;
    logic [1:0]  destination;
    logic [1:0]  runout_policy;
    logic [11:0] capture_limit;
    logic [31:0] region_bytes;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] packet_length;
    logic [1:0]  ring_kind;
    logic        descriptor_present;
  } item_t;

  typedef struct packed {
    logic        console_dump;
    logic        header_write;
    logic        header_valid;
    logic [9:0]  slot_index;
    logic [31:0] data_offset;
    logic [11:0] capture_length;
    logic [31:0] sequence_number;
    logic [1:0]  ring_kind_out;
    logic        full_event;
    logic        descriptor_dump;
    logic        table_clear;
  } result_t;

endpackage

// ===== hw/rtl/packet_capture_ring_manager_core.sv =====
// packet_capture_ring_manager_core: top level of the packet capture ring manager
// depends on pcrm_pkg, pcrm_cfg_regs, pcrm_ring_engine, pcrm_out_stage
//
//   channel   handshake             payload
//   input     in_valid / in_ready   mode, packet_length, ring_kind, descriptor_present
//   output    out_valid / out_ready console_dump .. table_clear (11 fields)
//   config    cfg_write             cfg_index, cfg_data (no wait, no read-back)
//
// one word per cycle sustained while out_ready is high; a result appears in the cycle after its word is taken
// the decision is one compare-and-add pass from the ring state into the result register
// in_ready is low only while the result register is full and out_ready is low
// rst is synchronous: registers to defaults, slot 0, offset 0, sequence 1

module packet_capture_ring_manager_core #(
  parameter int SLOT_COUNT      = 1024,
  parameter int DATA_START      = 65536,
  parameter int MAX_CAPTURE     = 2048,
  parameter int DEFAULT_CAPTURE = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pcrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcrm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [15:0]                     packet_length,
  input  logic [1:0]                      ring_kind,
  input  logic                            descriptor_present,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            console_dump,
  output logic                            header_write,
  output logic                            header_valid,
  output logic [9:0]                      slot_index,
  output logic [31:0]                     data_offset,
  output logic [11:0]                     capture_length,
  output logic [31:0]                     sequence_number,
  output logic [1:0]                      ring_kind_out,
  output logic                            full_event,
  output logic                            descriptor_dump,
  output logic                            table_clear
);

  pcrm_pkg::cfg_t    cfg;
  pcrm_pkg::item_t   item;
  pcrm_pkg::result_t result;
  pcrm_pkg::result_t out_data;
  logic              fire;

  assign item.mode               = mode;
  assign item.packet_length      = packet_length;
  assign item.ring_kind          = ring_kind;
  assign item.descriptor_present = descriptor_present;
  assign fire                    = in_valid && in_ready;

  pcrm_cfg_regs #(
    .MAX_CAPTURE    (MAX_CAPTURE),
    .DEFAULT_CAPTURE(DEFAULT_CAPTURE)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  pcrm_ring_engine #(
    .SLOT_COUNT(SLOT_COUNT),
    .DATA_START(DATA_START)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .item  (item),
    .fire  (fire),
    .result(result)
  );

  pcrm_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .load_data(result),
    .can_load (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign console_dump    = out_data.console_dump;
  assign header_write    = out_data.header_write;
  assign header_valid    = out_data.header_valid;
  assign slot_index      = out_data.slot_index;
  assign data_offset     = out_data.data_offset;
  assign capture_length  = out_data.capture_length;
  assign sequence_number = out_data.sequence_number;
  assign ring_kind_out   = out_data.ring_kind_out;
  assign full_event      = out_data.full_event;
  assign descriptor_dump = out_data.descriptor_dump;
  assign table_clear     = out_data.table_clear;

endmodule

// ===== hw/rtl/pcrm_cfg_regs.sv =====
// pcrm_cfg_regs: configuration register file with write filtering and saturation
// depends on pcrm_pkg

module pcrm_cfg_regs #(
  parameter int MAX_CAPTURE     = 2048,
  parameter int DEFAULT_CAPTURE = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pcrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcrm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pcrm_pkg::cfg_t                   cfg
);

  localparam logic [31:0] MAX_CAP_W = 32'(MAX_CAPTURE);

  logic [11:0] limit_next;

  always_comb begin
    if (32'(cfg_data[11:0]) < MAX_CAP_W) begin
      limit_next = cfg_data[11:0];
    end else begin
      limit_next = MAX_CAP_W[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capture_enable    <= 1'b0;
      cfg.descriptor_enable <= 1'b0;
      cfg.destination       <= pcrm_pkg::DEST_CONSOLE;
      cfg.runout_policy     <= pcrm_pkg::POLICY_WRAP;
      cfg.capture_limit     <= 12'(DEFAULT_CAPTURE);
      cfg.region_bytes      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pcrm_pkg::REG_CAPTURE_ENABLE:    cfg.capture_enable    <= cfg_data[0];
        pcrm_pkg::REG_DESCRIPTOR_ENABLE: cfg.descriptor_enable <= cfg_data[0];
        pcrm_pkg::REG_DESTINATION: begin
          if (cfg_data[1:0] != pcrm_pkg::DEST_BAD) cfg.destination <= cfg_data[1:0];
        end
        pcrm_pkg::REG_RUNOUT_POLICY: begin
          if (cfg_data[1:0] != pcrm_pkg::POLICY_BAD) cfg.runout_policy <= cfg_data[1:0];
        end
        pcrm_pkg::REG_CAPTURE_LIMIT:     cfg.capture_limit     <= limit_next;
        pcrm_pkg::REG_REGION_BYTES:      cfg.region_bytes      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pcrm_ring_engine.sv =====
// pcrm_ring_engine: slot and offset state, overflow test and per-word decision
// depends on pcrm_pkg; fed by pcrm_cfg_regs, feeds pcrm_out_stage

module pcrm_ring_engine #(
  parameter int SLOT_COUNT = 1024,
  parameter int DATA_START = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  pcrm_pkg::cfg_t    cfg,
  input  pcrm_pkg::item_t   item,
  input  logic              fire,
  output pcrm_pkg::result_t result
);

  localparam int          SLOT_W    = $clog2(SLOT_COUNT);
  localparam logic [31:0] SLOT_LAST = 32'(SLOT_COUNT - 1);
  localparam logic [33:0] START_W   = 34'(DATA_START);

  logic [SLOT_W-1:0] next_slot;
  logic [SLOT_W-1:0] next_slot_next;
  logic [31:0]       write_offset;
  logic [31:0]       write_offset_next;
  logic [31:0]       sequence_counter;
  logic [31:0]       sequence_counter_next;

  logic [11:0]       cap;
  logic              slot_full;
  logic              region_over;
  logic              over;
  logic              wrap;
  logic              store;
  logic [SLOT_W-1:0] eff_slot;
  logic [31:0]       eff_offset;
  logic [31:0]       slot_wide;

  always_comb begin
    if (16'(cfg.capture_limit) > item.packet_length) begin
      cap = item.packet_length[11:0];
    end else begin
      cap = cfg.capture_limit;
    end
    slot_full   = 32'(next_slot) >= SLOT_LAST;
    region_over = (START_W + {2'b00, write_offset} + 34'(cap)) > {2'b00, cfg.region_bytes};
    over        = slot_full || region_over;
    wrap        = over && (cfg.runout_policy == pcrm_pkg::POLICY_WRAP);
    store       = !over || wrap;
    eff_slot    = wrap ? '0 : next_slot;
    eff_offset  = wrap ? '0 : write_offset;
    slot_wide   = 32'(eff_slot);
  end

  always_comb begin
    result                = '0;
    next_slot_next        = next_slot;
    write_offset_next     = write_offset;
    sequence_counter_next = sequence_counter;
    if (item.mode == pcrm_pkg::MODE_REWIND) begin
      result.table_clear = 1'b1;
      next_slot_next     = '0;
      write_offset_next  = '0;
    end else begin
      result.descriptor_dump = cfg.descriptor_enable && item.descriptor_present;
      result.capture_length  = cap;
      result.sequence_number = sequence_counter;
      sequence_counter_next  = sequence_counter + 32'd1;
      if (cfg.capture_enable) begin
        result.console_dump = (cfg.destination == pcrm_pkg::DEST_CONSOLE) ||
                              (cfg.destination == pcrm_pkg::DEST_BOTH);
        if ((cfg.destination == pcrm_pkg::DEST_MEMORY) ||
            (cfg.destination == pcrm_pkg::DEST_BOTH)) begin
          result.header_write  = 1'b1;
          result.slot_index    = slot_wide[9:0];
          result.ring_kind_out = item.ring_kind;
          result.full_event    = over && (cfg.runout_policy == pcrm_pkg::POLICY_NOTIFY);
          if (store) begin
            result.header_valid = 1'b1;
            result.data_offset  = eff_offset;
            write_offset_next   = eff_offset + 32'(cap);
            next_slot_next      = eff_slot + SLOT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot        <= '0;
      write_offset     <= '0;
      sequence_counter <= 32'd1;
    end else if (fire) begin
      next_slot        <= next_slot_next;
      write_offset     <= write_offset_next;
      sequence_counter <= sequence_counter_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(next_slot) <= SLOT_LAST)
    else $error("slot pointer beyond table");
  a_rewind_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && item.mode == pcrm_pkg::MODE_REWIND) |=> (next_slot == '0 && write_offset == '0))
    else $error("rewind did not reset ring");
  a_seq_advances: assert property (@(posedge clk) disable iff (rst)
    (fire && item.mode == pcrm_pkg::MODE_PACKET) |=>
      (sequence_counter == $past(sequence_counter) + 32'd1))
    else $error("sequence counter did not advance");
  a_valid_needs_write: assert property (@(posedge clk) disable iff (rst)
    (result.header_valid || result.full_event) |-> result.header_write)
    else $error("header flags without header write");
`endif

endmodule

// ===== hw/rtl/pcrm_out_stage.sv =====
// pcrm_out_stage: result register with valid/ready handshake
// depends on pcrm_pkg

module pcrm_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pcrm_pkg::result_t load_data,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output pcrm_pkg::result_t out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule
